### sv/first_fit_block_allocator_defines.svh
// assertion macros for the first-fit block allocator
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// assertion sampled on the rising clock edge, off while reset is held
`define FFBA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// assertion sampled on the rising clock edge, checked during reset too
`define FFBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFBA_ASSERT(lbl, clk, rstn, prop, msg)
`define FFBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### sv/ffba_pkg.sv
// shared types and constants of the first-fit block allocator
package ffba_pkg;

    localparam int unsigned MAX_BLOCKS_DEF   = 64;
    localparam int unsigned HEADER_BYTES_DEF = 16;
    localparam int unsigned ALIGN_BYTES_DEF  = 16;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned IN_TDATA_W  = 64;
    localparam int unsigned OUT_FIELDS_W = 3 + 3 * ADDR_W;
    localparam int unsigned OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [ADDR_W-1:0] REGION_START_RST = 32'h0000_0000;
    localparam logic [ADDR_W-1:0] REGION_END_RST   = 32'h0010_0000;

    // configuration register indexes
    typedef enum logic {
        REG_REGION_START = 1'b0,
        REG_REGION_END   = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_NO_SPACE    = 3'd1,
        STAT_BAD_ARG     = 3'd2,
        STAT_UNKNOWN     = 3'd3,
        STAT_TABLE_FULL  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_NB_RD,
        ST_NB_CHK_NEXT,
        ST_NB_CHK_PREV,
        ST_SH_RD,
        ST_SH_WR,
        ST_FIN_A,
        ST_FIN_B,
        ST_DONE
    } state_t;

    // one row of the block table
    typedef struct packed {
        logic              in_use;
        logic [ADDR_W-1:0] payload;
        logic [ADDR_W-1:0] base;
    } entry_t;

endpackage

### sv/first_fit_block_allocator.sv
// First-fit block allocator: the block table (base, payload, in-use) sits in one
// single-port-read synchronous memory walked by a sequencer, one item at a time.
// ALIGN_BYTES must be a power of two; the request is rounded up with a mask as the
// beat is taken. An allocate reads and checks each table entry in turn up to the
// first fit (with one more read when nothing fits), then on a split moves each
// entry above the fit up by a read and a write to open a slot and writes both parts.
// A free reads and checks each entry in turn, reads its neighbours (NB_RD,
// NB_CHK_NEXT, NB_CHK_PREV), moves each entry down by a read and a write after a
// merge and writes the merged block. Either then loads the result register once
// the output is free, and its beat is offered on the next cycle. All of it is bound
// by the one read per cycle of the table memory. After reset or any configuration
// write the block rebuilds the table in ST_INIT before it accepts a beat.
`include "first_fit_block_allocator_defines.svh"

module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int unsigned ALIGN_BYTES  = ALIGN_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [0:0]             cfg_addr,
    input  logic [ADDR_W-1:0]      cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // req_size[31:0], payload_addr[63:32]
    input  logic [0:0]             s_tuser,   // action
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status[2:0], result_addr[34:3], free_bytes[66:35], used_bytes[98:67], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int unsigned IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned CW  = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned XW  = ADDR_W + 1;
    localparam int unsigned PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [CW-1:0]     MAX_CNT = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0]     ONE_CNT = CW'(1);
    localparam logic [ADDR_W-1:0] HDR     = ADDR_W'(HEADER_BYTES);
    localparam logic [XW-1:0]     ALIGN_M1 = XW'(ALIGN_BYTES - 1);

    // block table memory
    entry_t           mem [MAX_BLOCKS];
    entry_t           rd_q;
    logic [IW-1:0]    rd_addr;
    logic             mem_we;
    logic [IW-1:0]    mem_wa;
    entry_t           mem_wd;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  region_start_reg, region_start_next;
    logic [ADDR_W-1:0]  region_end_reg, region_end_next;
    logic               init_pend_reg, init_pend_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               act_reg, act_next;
    logic [ADDR_W-1:0]  paddr_reg, paddr_next;
    logic [XW-1:0]      rnd_reg, rnd_next;
    logic [XW:0]        need_reg, need_next;
    entry_t             ent_reg, ent_next;
    logic [CW-1:0]      tgt_reg, tgt_next;
    logic               nxt_free_reg, nxt_free_next;
    logic [ADDR_W-1:0]  nxt_pay_reg, nxt_pay_next;
    logic [1:0]         shr_reg, shr_next;
    logic [CW-1:0]      sh_src_reg, sh_src_next;
    logic [CW-1:0]      sh_stop_reg, sh_stop_next;
    logic               sh_up_reg, sh_up_next;
    status_t            status_reg, status_next;
    logic [ADDR_W-1:0]  raddr_reg, raddr_next;
    logic [ADDR_W-1:0]  free_tot_reg, free_tot_next;
    logic [ADDR_W-1:0]  used_tot_reg, used_tot_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    // helper terms used by the sequencer and datapath
    logic               hit;
    logic               exact;
    logic               prv_free;
    logic [1:0]         merge_n;
    logic [CW-1:0]      mrg_tgt;
    logic [CW-1:0]      mrg_start;
    logic [ADDR_W-1:0]  region_size;
    logic [ADDR_W-1:0]  init_pay;
    logic [XW-1:0]      rnd_in;
    logic               out_free;

    always_comb begin
        if (act_reg == ACT_FREE) begin
            hit = rd_q.in_use && ((rd_q.base + HDR) == paddr_reg);
        end else begin
            hit = !rd_q.in_use && ({2'b00, rd_q.payload} >= need_reg);
        end
        exact     = ({2'b00, rd_q.payload} == need_reg);
        prv_free  = (tgt_reg != '0) && !rd_q.in_use;
        merge_n   = {1'b0, nxt_free_reg} + {1'b0, prv_free};
        mrg_tgt   = prv_free ? (tgt_reg - ONE_CNT) : tgt_reg;
        mrg_start = mrg_tgt + ONE_CNT + CW'(merge_n);
        region_size = (region_end_reg > region_start_reg) ?
                      (region_end_reg - region_start_reg) : '0;
        init_pay  = (region_size >= HDR) ? (region_size - HDR) : '0;
        // round up to the alignment without wrap
        rnd_in    = ({1'b0, s_tdata[31:0]} + ALIGN_M1) & ~ALIGN_M1;
        out_free  = !m_valid_reg || m_tready;
    end

    // table read address
    always_comb begin
        case (state_reg)
            ST_SH_RD:       rd_addr = sh_src_reg[IW-1:0];
            ST_NB_RD:       rd_addr = IW'(tgt_reg + ONE_CNT);
            ST_NB_CHK_NEXT: rd_addr = IW'(tgt_reg - ONE_CNT);
            default:        rd_addr = idx_reg[IW-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_q <= mem[rd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (init_pend_reg) begin
                    state_next = ST_INIT;
                end else if (s_tvalid) begin
                    if (s_tuser[0] == ACT_FREE) begin
                        state_next = (s_tdata[63:32] == '0) ? ST_DONE : ST_SRCH_RD;
                    end else begin
                        state_next = (s_tdata[31:0] == '0) ? ST_DONE : ST_SRCH_RD;
                    end
                end
            end
            ST_INIT:  state_next = ST_IDLE;
            ST_SRCH_RD: state_next = (idx_reg >= cnt_reg) ? ST_DONE : ST_SRCH_CHK;
            ST_SRCH_CHK: begin
                if (!hit) begin
                    state_next = ST_SRCH_RD;
                end else if (act_reg == ACT_FREE) begin
                    state_next = ST_NB_RD;
                end else if (exact || (cnt_reg >= MAX_CNT)) begin
                    state_next = ST_DONE;
                end else if ((idx_reg + ONE_CNT) < cnt_reg) begin
                    state_next = ST_SH_RD;
                end else begin
                    state_next = ST_FIN_A;
                end
            end
            ST_NB_RD:       state_next = ST_NB_CHK_NEXT;
            ST_NB_CHK_NEXT: state_next = ST_NB_CHK_PREV;
            ST_NB_CHK_PREV: begin
                if ((merge_n == 2'd0) || (mrg_start >= cnt_reg)) begin
                    state_next = ST_FIN_A;
                end else begin
                    state_next = ST_SH_RD;
                end
            end
            ST_SH_RD: state_next = ST_SH_WR;
            ST_SH_WR: state_next = (sh_src_reg == sh_stop_reg) ? ST_FIN_A : ST_SH_RD;
            ST_FIN_A: state_next = (act_reg == ACT_FREE) ? ST_DONE : ST_FIN_B;
            ST_FIN_B: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and table writes
    always_comb begin
        region_start_next = region_start_reg;
        region_end_next   = region_end_reg;
        init_pend_next    = init_pend_reg;
        cnt_next          = cnt_reg;
        idx_next          = idx_reg;
        act_next          = act_reg;
        paddr_next        = paddr_reg;
        rnd_next          = rnd_reg;
        need_next         = need_reg;
        ent_next          = ent_reg;
        tgt_next          = tgt_reg;
        nxt_free_next     = nxt_free_reg;
        nxt_pay_next      = nxt_pay_reg;
        shr_next          = shr_reg;
        sh_src_next       = sh_src_reg;
        sh_stop_next      = sh_stop_reg;
        sh_up_next        = sh_up_reg;
        status_next       = status_reg;
        raddr_next        = raddr_reg;
        free_tot_next     = free_tot_reg;
        used_tot_next     = used_tot_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;
        mem_we            = 1'b0;
        mem_wa            = tgt_reg[IW-1:0];
        mem_wd            = ent_reg;
        s_tready          = (state_reg == ST_IDLE) && !init_pend_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                // latch the incoming beat
                if (s_tready && s_tvalid) begin
                    act_next   = s_tuser[0];
                    paddr_next = s_tdata[63:32];
                    idx_next   = '0;
                    raddr_next = '0;
                    rnd_next   = rnd_in;
                    need_next  = {1'b0, rnd_in} + (XW + 1)'(HEADER_BYTES);
                    status_next = STAT_OK;
                    if ((s_tuser[0] == ACT_FREE) && (s_tdata[63:32] == '0)) begin
                        status_next = STAT_BAD_ARG;
                    end
                    if ((s_tuser[0] == ACT_ALLOC) && (s_tdata[31:0] == '0)) begin
                        status_next = STAT_BAD_ARG;
                    end
                end
            end
            ST_INIT: begin
                // whole region becomes one free block
                mem_we         = 1'b1;
                mem_wa         = '0;
                mem_wd         = '{in_use: 1'b0, payload: init_pay, base: region_start_reg};
                cnt_next       = ONE_CNT;
                free_tot_next  = init_pay;
                used_tot_next  = '0;
                init_pend_next = 1'b0;
            end
            ST_SRCH_RD: begin
                if (idx_reg >= cnt_reg) begin
                    status_next = (act_reg == ACT_FREE) ? STAT_UNKNOWN : STAT_NO_SPACE;
                end
            end
            ST_SRCH_CHK: begin
                // first-fit compare on the entry just read
                if (!hit) begin
                    idx_next = idx_reg + ONE_CNT;
                end else begin
                    ent_next = rd_q;
                    tgt_next = idx_reg;
                    if (act_reg == ACT_ALLOC) begin
                        if (exact) begin
                            mem_we        = 1'b1;
                            mem_wa        = idx_reg[IW-1:0];
                            mem_wd        = '{in_use: 1'b1, payload: rd_q.payload,
                                              base: rd_q.base};
                            free_tot_next = free_tot_reg - rd_q.payload;
                            used_tot_next = used_tot_reg + rd_q.payload;
                            raddr_next    = rd_q.base + HDR;
                        end else if (cnt_reg >= MAX_CNT) begin
                            status_next = STAT_TABLE_FULL;
                        end else begin
                            sh_src_next  = cnt_reg - ONE_CNT;
                            sh_stop_next = idx_reg + ONE_CNT;
                            sh_up_next   = 1'b1;
                        end
                    end
                end
            end
            ST_NB_CHK_NEXT: begin
                nxt_free_next = ((tgt_reg + ONE_CNT) < cnt_reg) && !rd_q.in_use;
                nxt_pay_next  = rd_q.payload;
            end
            ST_NB_CHK_PREV: begin
                // merged block and the shift that closes the gap
                ent_next.in_use  = 1'b0;
                ent_next.base    = prv_free ? rd_q.base : ent_reg.base;
                ent_next.payload = ent_reg.payload
                                 + (nxt_free_reg ? (nxt_pay_reg + HDR) : '0)
                                 + (prv_free ? (rd_q.payload + HDR) : '0);
                tgt_next      = mrg_tgt;
                shr_next      = merge_n;
                sh_src_next   = mrg_start;
                sh_stop_next  = cnt_reg - ONE_CNT;
                sh_up_next    = 1'b0;
                cnt_next      = cnt_reg - CW'(merge_n);
                used_tot_next = used_tot_reg - ent_reg.payload;
                free_tot_next = free_tot_reg + ent_reg.payload
                              + (nxt_free_reg ? HDR : '0) + (prv_free ? HDR : '0);
            end
            ST_SH_WR: begin
                // move one entry up or down
                mem_we = 1'b1;
                mem_wd = rd_q;
                if (sh_up_reg) begin
                    mem_wa      = IW'(sh_src_reg + ONE_CNT);
                    sh_src_next = sh_src_reg - ONE_CNT;
                end else begin
                    mem_wa      = IW'(sh_src_reg - CW'(shr_reg));
                    sh_src_next = sh_src_reg + ONE_CNT;
                end
            end
            ST_FIN_A: begin
                mem_we = 1'b1;
                if (act_reg == ACT_ALLOC) begin
                    // free remainder of the split
                    mem_wa = IW'(tgt_reg + ONE_CNT);
                    mem_wd = '{in_use: 1'b0,
                               payload: ent_reg.payload - need_reg[ADDR_W-1:0],
                               base: ent_reg.base + need_reg[ADDR_W-1:0]};
                end else begin
                    mem_wa = tgt_reg[IW-1:0];
                    mem_wd = ent_reg;
                end
            end
            ST_FIN_B: begin
                // used part of the split
                mem_we        = 1'b1;
                mem_wa        = tgt_reg[IW-1:0];
                mem_wd        = '{in_use: 1'b1, payload: rnd_reg[ADDR_W-1:0],
                                  base: ent_reg.base};
                cnt_next      = cnt_reg + ONE_CNT;
                free_tot_next = free_tot_reg - need_reg[ADDR_W-1:0];
                used_tot_next = used_tot_reg + rnd_reg[ADDR_W-1:0];
                raddr_next    = ent_reg.base + HDR;
            end
            ST_DONE: begin
                // hand the result to the output register
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{PAD_W{1'b0}}, used_tot_reg, free_tot_reg,
                                    raddr_reg, status_reg};
                end
            end
            default: begin
            end
        endcase

        // configuration writes rebuild the table
        if (cfg_wr_en) begin
            init_pend_next = 1'b1;
            case (cfg_addr[0])
                REG_REGION_START: region_start_next = cfg_wr_data;
                REG_REGION_END:   region_end_next   = cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            region_start_reg <= REGION_START_RST;
            region_end_reg   <= REGION_END_RST;
            init_pend_reg    <= 1'b1;
            cnt_reg          <= ONE_CNT;
            free_tot_reg     <= '0;
            used_tot_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            region_start_reg <= region_start_next;
            region_end_reg   <= region_end_next;
            init_pend_reg    <= init_pend_next;
            cnt_reg          <= cnt_next;
            free_tot_reg     <= free_tot_next;
            used_tot_reg     <= used_tot_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        act_reg      <= act_next;
        paddr_reg    <= paddr_next;
        rnd_reg      <= rnd_next;
        need_reg     <= need_next;
        ent_reg      <= ent_next;
        tgt_reg      <= tgt_next;
        nxt_free_reg <= nxt_free_next;
        nxt_pay_reg  <= nxt_pay_next;
        shr_reg      <= shr_next;
        sh_src_reg   <= sh_src_next;
        sh_stop_reg  <= sh_stop_next;
        sh_up_reg    <= sh_up_next;
        status_reg   <= status_next;
        raddr_reg    <= raddr_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // checks
    `FFBA_ASSERT(a_cnt_range, aclk, aresetn, (cnt_reg != '0) && (cnt_reg <= MAX_CNT), "block count out of range")
    `FFBA_ASSERT(a_idle_no_write, aclk, aresetn, (state_reg == ST_IDLE) |-> !mem_we, "table written while idle")
    `FFBA_ASSERT(a_fail_no_addr, aclk, aresetn, (m_valid_reg && (m_data_reg[2:0] != STAT_OK)) |-> (m_data_reg[34:3] == '0), "failed request returned an address")

endmodule
